### rtl/ssfm_pkg.sv
`default_nettype none

package ssfm_pkg;

  // Fixed field widths of the configuration and data ports.
  localparam int BYTE_BITS      = 8;
  localparam int LEN_REG_BITS   = 6;
  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_INDEX_BITS = 3;

  // The needle registers hold this many bytes; bytes beyond them read as zero.
  localparam int NEEDLE_STORE_BYTES = 32;
  localparam int BYTES_PER_REG      = CFG_DATA_BITS / BYTE_BITS;

  // Entries in the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_NEEDLE_LENGTH = 3'd0,
    REG_NEEDLE_LO     = 3'd1,
    REG_NEEDLE_MID_LO = 3'd2,
    REG_NEEDLE_MID_HI = 3'd3,
    REG_NEEDLE_HI     = 3'd4
  } cfg_reg_t;

  // What the front part learned about one haystack byte.
  typedef struct packed {
    logic hit;           // the window ending at this byte matches the needle
    logic last;          // this byte closes the haystack
    logic empty_needle;  // the needle length in use is zero
  } ssfm_flags_t;

endpackage

`default_nettype wire

### rtl/substring_first_match_search.sv
`default_nettype none

// Streaming first-occurrence substring search. The needle (up to
// MAX_NEEDLE_BYTES bytes) and its length are to be set through the write port
// only while the block is idle, which the block does not enforce. Haystack
// bytes then arrive on the text channel, with text_end on the final byte. For
// each haystack exactly one result comes out: found and the byte offset of the
// first occurrence (zero when not found; an empty needle is found at zero).
// The block takes one byte per clock cycle while text_ready is high, a rate
// set by the combinational compare of the whole window against the needle in
// the front stage. A four-entry queue between the compare stage and the result
// stage, ahead of the output register, lets input continue while a result
// waits. After reset and after every configuration write, text_ready is held
// low while the reversed needle is reloaded. The byte counter saturates at
// 2**POSITION_BITS-1; no match ending beyond that point is seen.

module substring_first_match_search #(
  parameter int MAX_NEEDLE_BYTES = 32,
  parameter int POSITION_BITS    = 24
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write_en,
  input  wire logic [ssfm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [ssfm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                                text_valid,
  output logic                                     text_ready,
  input  wire logic [ssfm_pkg::BYTE_BITS-1:0]      text_byte,
  input  wire logic                                text_end,
  output logic                                     result_valid,
  input  wire logic                                result_ready,
  output logic                                     found,
  output logic [POSITION_BITS-1:0]                 match_position
);

  import ssfm_pkg::*;

  localparam int ENTRY_BITS = $bits(ssfm_flags_t) + POSITION_BITS;

  logic                     push;
  ssfm_flags_t              push_flags;
  logic [POSITION_BITS-1:0] push_pos;
  logic                     queue_ready;
  logic                     entry_valid;
  logic                     entry_ready;
  logic [ENTRY_BITS-1:0]    entry_data;
  ssfm_flags_t              entry_flags;
  logic [POSITION_BITS-1:0] entry_pos;

  // Window, counter and compare.
  ssfm_front #(
    .MAX_NEEDLE_BYTES (MAX_NEEDLE_BYTES),
    .POSITION_BITS    (POSITION_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .text_valid   (text_valid),
    .text_ready   (text_ready),
    .text_byte    (text_byte),
    .text_end     (text_end),
    .push         (push),
    .push_flags   (push_flags),
    .push_pos     (push_pos),
    .queue_ready  (queue_ready)
  );

  // Classified bytes wait here for the result stage.
  ssfm_queue #(
    .DATA_BITS (ENTRY_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push),
    .in_ready  (queue_ready),
    .in_data   ({push_flags, push_pos}),
    .out_valid (entry_valid),
    .out_ready (entry_ready),
    .out_data  (entry_data)
  );

  assign entry_flags = entry_data[ENTRY_BITS-1:POSITION_BITS];
  assign entry_pos   = entry_data[POSITION_BITS-1:0];

  // First-match latch and output register.
  ssfm_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .entry_valid    (entry_valid),
    .entry_ready    (entry_ready),
    .entry_flags    (entry_flags),
    .entry_pos      (entry_pos),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .found          (found),
    .match_position (match_position)
  );

endmodule

`default_nettype wire

### rtl/ssfm_front.sv
`default_nettype none

module ssfm_front #(
  parameter int MAX_NEEDLE_BYTES = 32,
  parameter int POSITION_BITS    = 24
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write_en,
  input  wire logic [ssfm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [ssfm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                                text_valid,
  output logic                                     text_ready,
  input  wire logic [ssfm_pkg::BYTE_BITS-1:0]      text_byte,
  input  wire logic                                text_end,
  output logic                                     push,
  output ssfm_pkg::ssfm_flags_t                    push_flags,
  output logic [POSITION_BITS-1:0]                 push_pos,
  input  wire logic                                queue_ready
);

  import ssfm_pkg::*;

  localparam int LEN_BITS = (MAX_NEEDLE_BYTES < 2) ? 1 : $clog2(MAX_NEEDLE_BYTES + 1);

  // Configuration registers.
  logic [LEN_REG_BITS-1:0]                   needle_length;
  logic [NEEDLE_STORE_BYTES*BYTE_BITS-1:0]   needle_flat;

  // Needle laid out against the window, registered from the configuration registers.
  logic [MAX_NEEDLE_BYTES-1:0][BYTE_BITS-1:0] aligned;
  logic [MAX_NEEDLE_BYTES-1:0][BYTE_BITS-1:0] aligned_next;
  logic [MAX_NEEDLE_BYTES-1:0]                mask;
  logic [MAX_NEEDLE_BYTES-1:0]                mask_next;
  logic [LEN_BITS-1:0]                        len_active;
  logic [LEN_BITS-1:0]                        len_active_next;
  logic                                       settle;

  // Haystack state: window of recent bytes (entry 0 newest) and byte count.
  logic [MAX_NEEDLE_BYTES-1:0][BYTE_BITS-1:0] window;
  logic [MAX_NEEDLE_BYTES-1:0][BYTE_BITS-1:0] window_next;
  logic [POSITION_BITS-1:0]                   bytes_seen;
  logic [POSITION_BITS-1:0]                   bytes_seen_next;
  logic                                       counted;
  logic [MAX_NEEDLE_BYTES-1:0]                byte_equal;
  logic                                       window_match;
  logic [POSITION_BITS-1:0]                   len_wide;
  logic                                       accept;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      needle_length <= '0;
      needle_flat   <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_NEEDLE_LENGTH: needle_length <= cfg_data[LEN_REG_BITS-1:0];
        REG_NEEDLE_LO:     needle_flat[0*CFG_DATA_BITS +: CFG_DATA_BITS] <= cfg_data;
        REG_NEEDLE_MID_LO: needle_flat[1*CFG_DATA_BITS +: CFG_DATA_BITS] <= cfg_data;
        REG_NEEDLE_MID_HI: needle_flat[2*CFG_DATA_BITS +: CFG_DATA_BITS] <= cfg_data;
        REG_NEEDLE_HI:     needle_flat[3*CFG_DATA_BITS +: CFG_DATA_BITS] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the length and reverse the needle so that window entry k faces
  // needle byte len-1-k.
  always_comb begin
    int j;
    j = 0;
    if (int'(needle_length) > MAX_NEEDLE_BYTES) begin
      len_active_next = LEN_BITS'(MAX_NEEDLE_BYTES);
    end else begin
      len_active_next = LEN_BITS'(needle_length);
    end
    for (int k = 0; k < MAX_NEEDLE_BYTES; k++) begin
      j = int'(len_active_next) - 1 - k;
      mask_next[k] = (k < int'(len_active_next));
      if (j >= 0 && j < NEEDLE_STORE_BYTES) begin
        aligned_next[k] = needle_flat[BYTE_BITS*j +: BYTE_BITS];
      end else begin
        aligned_next[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    aligned    <= aligned_next;
    mask       <= mask_next;
    len_active <= len_active_next;
  end

  // Hold off input in the cycle after reset or a write so the aligned
  // needle has caught up.
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= 1'b1;
    end else begin
      settle <= cfg_write_en;
    end
  end

  assign text_ready = queue_ready && !settle;
  assign accept     = text_valid && text_ready;

  // Window after this byte is shifted in, and the saturating count.
  always_comb begin
    window_next[0] = text_byte;
    for (int k = 1; k < MAX_NEEDLE_BYTES; k++) begin
      window_next[k] = window[k-1];
    end
  end

  assign counted         = (bytes_seen != '1);
  assign bytes_seen_next = counted ? bytes_seen + POSITION_BITS'(1) : bytes_seen;
  assign len_wide        = POSITION_BITS'(len_active);

  // Full window compare against the aligned needle.
  always_comb begin
    for (int k = 0; k < MAX_NEEDLE_BYTES; k++) begin
      byte_equal[k] = !mask[k] || (window_next[k] == aligned[k]);
    end
  end

  assign window_match = &byte_equal;

  // Classify the byte for the back part.
  assign push                    = accept;
  assign push_flags.hit          = window_match && counted && (len_active != '0) &&
                                   (bytes_seen_next >= len_wide);
  assign push_flags.last         = text_end;
  assign push_flags.empty_needle = (len_active == '0);
  assign push_pos                = bytes_seen_next - len_wide;

  // The haystack state clears after its final byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= '0;
      bytes_seen <= '0;
    end else if (accept) begin
      if (text_end) begin
        window     <= '0;
        bytes_seen <= '0;
      end else begin
        window     <= window_next;
        bytes_seen <= bytes_seen_next;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/ssfm_queue.sv
`default_nettype none

module ssfm_queue #(
  parameter int DATA_BITS = 27
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [DATA_BITS-1:0] in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [DATA_BITS-1:0]      out_data
);

  import ssfm_pkg::*;

  localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_BITS-1:0]  slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [COUNT_BITS-1:0] fill;
  logic                  do_push;
  logic                  do_pop;

  assign in_ready  = (fill != COUNT_BITS'(QUEUE_DEPTH));
  assign out_valid = (fill != '0);
  assign out_data  = slots[rd_ptr];
  assign do_push   = in_valid && in_ready;
  assign do_pop    = out_valid && out_ready;

  // Storage; the pointers wrap since the depth is a power of two.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= in_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + COUNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - COUNT_BITS'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/ssfm_back.sv
`default_nettype none

module ssfm_back #(
  parameter int POSITION_BITS = 24
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     entry_valid,
  output logic                          entry_ready,
  input  wire ssfm_pkg::ssfm_flags_t    entry_flags,
  input  wire logic [POSITION_BITS-1:0] entry_pos,
  output logic                          result_valid,
  input  wire logic                     result_ready,
  output logic                          found,
  output logic [POSITION_BITS-1:0]      match_position
);

  import ssfm_pkg::*;

  logic                     match_latched;
  logic [POSITION_BITS-1:0] first_match_at;
  logic                     take;
  logic                     emit;

  // A closing byte waits until the output register is free or being read.
  assign entry_ready = !entry_flags.last || !result_valid || result_ready;
  assign take        = entry_valid && entry_ready;
  assign emit        = take && entry_flags.last;

  // First match latch, cleared at the end of each haystack.
  always_ff @(posedge clk) begin
    if (rst) begin
      match_latched  <= 1'b0;
      first_match_at <= '0;
    end else if (take) begin
      if (entry_flags.last) begin
        match_latched  <= 1'b0;
        first_match_at <= '0;
      end else if (!match_latched && entry_flags.hit) begin
        match_latched  <= 1'b1;
        first_match_at <= entry_pos;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      found <= entry_flags.empty_needle || match_latched || entry_flags.hit;
      if (entry_flags.empty_needle) begin
        match_position <= '0;
      end else if (match_latched) begin
        match_position <= first_match_at;
      end else if (entry_flags.hit) begin
        match_position <= entry_pos;
      end else begin
        match_position <= '0;
      end
    end
  end

endmodule

`default_nettype wire

### bench/substring_first_match_search_tb.sv
module substring_first_match_search_tb;
  import ssfm_pkg::*;

  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TOTAL_ITEMS   = 670;
  localparam int PHASE_ITEMS   = 55;
  localparam int POS_BITS      = 24;

  // Register indexes that map to no register; writes there must be ignored.
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_FIRST = 3'd5;
  localparam int                        REG_INDEX_TOP    = (1 << CFG_INDEX_BITS) - 1;

  typedef struct packed {
    logic                found;
    logic [POS_BITS-1:0] position;
  } outcome_t;

  typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic [CFG_INDEX_BITS-1:0] idx;
    logic [CFG_DATA_BITS-1:0]  data;
    logic [BYTE_BITS-1:0]      value;
    logic                      last;
    logic                      typed;
    logic                      want_found;
    logic [POS_BITS-1:0]       want_pos;
  } script_row_t;

  localparam int SCRIPT_ROWS = 25;

  // Directed haystacks. Outcomes are typed in where they are obvious.
  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    // Empty needle after reset: found at offset zero.
    '{ROW_BYTE,  3'd0, 64'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 24'd0},
    '{ROW_BYTE,  3'd0, 64'd0, 8'h00, 1'b1, 1'b1, 1'b1, 24'd0},
    // Single zero byte needle: a plain byte search.
    '{ROW_WRITE, REG_NEEDLE_LENGTH, 64'd1, 8'h00, 1'b0, 1'b0, 1'b0, 24'd0},
    '{ROW_WRITE, REG_NEEDLE_LO, 64'hFFFF_FFFF_FFFF_FF00, 8'h00, 1'b0, 1'b0, 1'b0, 24'd0},
    '{ROW_BYTE,  3'd0, 64'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 24'd0},
    '{ROW_BYTE,  3'd0, 64'd0, 8'h00, 1'b0, 1'b0, 1'b0, 24'd0},
    '{ROW_BYTE,  3'd0, 64'd0, 8'h00, 1'b1, 1'b1, 1'b1, 24'd1},
    // Not found reports position zero.
    '{ROW_BYTE,  3'd0, 64'd0, 8'h7F, 1'b1, 1'b1, 1'b0, 24'd0},
    // Three byte needle 01 FF 80.
    '{ROW_WRITE, REG_NEEDLE_LENGTH, 64'd3, 8'h00, 1'b0, 1'b0, 1'b0, 24'd0},
    '{ROW_WRITE, REG_NEEDLE_LO, 64'h0000_0000_0080_FF01, 8'h00, 1'b0, 1'b0, 1'b0, 24'd0},
    // Haystack shorter than the needle.
    '{ROW_BYTE,  3'd0, 64'd0, 8'h01, 1'b0, 1'b0, 1'b0, 24'd0},
    '{ROW_BYTE,  3'd0, 64'd0, 8'hFF, 1'b1, 1'b1, 1'b0, 24'd0},
    // Two occurrences; the first one, at offset 1, wins.
    '{ROW_BYTE,  3'd0, 64'd0, 8'h01, 1'b0, 1'b0, 1'b0, 24'd0},
    '{ROW_BYTE,  3'd0, 64'd0, 8'h01, 1'b0, 1'b0, 1'b0, 24'd0},
    '{ROW_BYTE,  3'd0, 64'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 24'd0},
    '{ROW_BYTE,  3'd0, 64'd0, 8'h80, 1'b0, 1'b0, 1'b0, 24'd0},
    '{ROW_BYTE,  3'd0, 64'd0, 8'h01, 1'b0, 1'b0, 1'b0, 24'd0},
    '{ROW_BYTE,  3'd0, 64'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 24'd0},
    '{ROW_BYTE,  3'd0, 64'd0, 8'h80, 1'b1, 1'b1, 1'b1, 24'd1},
    // A write to an unused index must leave the needle alone.
    '{ROW_WRITE, REG_UNUSED_FIRST, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0, 24'd0},
    '{ROW_BYTE,  3'd0, 64'd0, 8'h01, 1'b0, 1'b0, 1'b0, 24'd0},
    '{ROW_BYTE,  3'd0, 64'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 24'd0},
    '{ROW_BYTE,  3'd0, 64'd0, 8'h80, 1'b1, 1'b0, 1'b0, 24'd0},
    // Oversized length is clamped to the full 32 byte needle.
    '{ROW_WRITE, REG_NEEDLE_LENGTH, 64'd63, 8'h00, 1'b0, 1'b0, 1'b0, 24'd0},
    '{ROW_BYTE,  3'd0, 64'd0, 8'h01, 1'b1, 1'b1, 1'b0, 24'd0}
  };

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write_en = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      text_valid = 1'b0;
  logic                      text_ready;
  logic [BYTE_BITS-1:0]      text_byte = '0;
  logic                      text_end = 1'b0;
  logic                      result_valid;
  logic                      result_ready = 1'b0;
  logic                      found;
  logic [POS_BITS-1:0]       match_position;

  // Tags that travel with the item on the text channel.
  logic                row_typed = 1'b0;
  logic                row_found = 1'b0;
  logic [POS_BITS-1:0] row_pos = '0;

  outcome_t expected_outcomes[$];
  int       mismatch_count = 0;
  int       items_sent = 0;
  int       burst_left = 0;
  int       quiet_cycles = 0;
  logic [3:0]  stall_step = '0;
  logic [15:0] stall_word = 16'hFFFF;

  // Search state mirrored from the block.
  logic [BYTE_BITS-1:0]     window_bytes [NEEDLE_STORE_BYTES];
  logic [POS_BITS-1:0]      count_seen;
  logic                     hit_held;
  logic [POS_BITS-1:0]      hit_offset;
  logic [LEN_REG_BITS-1:0]  len_setting;
  logic [CFG_DATA_BITS-1:0] needle_words [4];

  substring_first_match_search uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .text_valid    (text_valid),
    .text_ready    (text_ready),
    .text_byte     (text_byte),
    .text_end      (text_end),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .found         (found),
    .match_position(match_position)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic int active_len();
    return (len_setting > NEEDLE_STORE_BYTES) ? NEEDLE_STORE_BYTES : int'(len_setting);
  endfunction

  function automatic logic [BYTE_BITS-1:0] needle_byte(input int j);
    if (j >= NEEDLE_STORE_BYTES) return '0;
    return needle_words[j / BYTES_PER_REG][BYTE_BITS * (j % BYTES_PER_REG) +: BYTE_BITS];
  endfunction

  task automatic restart_haystack();
    for (int i = 0; i < NEEDLE_STORE_BYTES; i++) window_bytes[i] = '0;
    count_seen = '0;
    hit_held = 1'b0;
    hit_offset = '0;
  endtask

  // Shift one byte into the window, latch the first full-window match and,
  // on the closing byte, produce the outcome for the haystack.
  task automatic scan_byte(input logic [BYTE_BITS-1:0] value, input logic last,
                           output logic has_outcome, output outcome_t outcome);
    int   len;
    logic counted;
    logic agree;
    len = active_len();
    counted = (count_seen != {POS_BITS{1'b1}});
    for (int i = NEEDLE_STORE_BYTES - 1; i > 0; i--) window_bytes[i] = window_bytes[i-1];
    window_bytes[0] = value;
    if (counted) count_seen = count_seen + 1'b1;
    if (!hit_held && counted && len > 0 && count_seen >= POS_BITS'(len)) begin
      agree = 1'b1;
      for (int j = 0; j < len; j++) begin
        if (window_bytes[len-1-j] != needle_byte(j)) agree = 1'b0;
      end
      if (agree) begin
        hit_held = 1'b1;
        hit_offset = count_seen - POS_BITS'(len);
      end
    end
    has_outcome = last;
    outcome = '0;
    if (last) begin
      if (len == 0) begin
        outcome.found = 1'b1;
      end else begin
        outcome.found = hit_held;
        outcome.position = hit_held ? hit_offset : '0;
      end
      restart_haystack();
    end
  endtask

  // One register write, followed by the write enable going low again.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == REG_NEEDLE_LENGTH) len_setting = data[LEN_REG_BITS-1:0];
    else if (idx <= REG_NEEDLE_HI) needle_words[2'(idx - REG_NEEDLE_LO)] = data;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    @(negedge clk);
  endtask

  // Hold the sender off until every outcome is back and the block has settled.
  task automatic wait_drained();
    text_valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Offer one haystack byte; the sender runs in bursts with gaps between them.
  task automatic push_byte(input logic [BYTE_BITS-1:0] value, input logic last,
                           input logic typed, input logic want_found,
                           input logic [POS_BITS-1:0] want_pos);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? 120 : $urandom_range(1, 12);
      text_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    text_valid <= 1'b1;
    text_byte <= value;
    text_end <= last;
    row_typed <= typed;
    row_found <= want_found;
    row_pos <= want_pos;
    @(posedge clk);
    while (!text_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Receiver stalls follow a 16-bit pattern word that is redrawn whenever the step counter wraps.
  always @(negedge clk) begin
    if (stall_step == 4'd0) begin
      stall_word = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    end
    result_ready <= stall_word[stall_step];
    stall_step <= stall_step + 4'd1;
  end

  // Predict on every accepted item and check every accepted result.
  always @(posedge clk) begin : scoreboard
    logic     has_outcome;
    outcome_t predicted;
    outcome_t want;
    if (rst) begin
      restart_haystack();
      len_setting = '0;
      for (int w = 0; w < 4; w++) needle_words[w] = '0;
    end else begin
      if (text_valid && text_ready) begin
        scan_byte(text_byte, text_end, has_outcome, predicted);
        if (has_outcome) begin
          if (row_typed) begin
            want.found = row_found;
            want.position = row_pos;
            expected_outcomes.push_back(want);
          end else begin
            expected_outcomes.push_back(predicted);
          end
        end
      end
      if (result_valid && result_ready) begin
        if (expected_outcomes.size() == 0) begin
          report_mismatch($sformatf("unexpected result found=%0b position=%0d",
                                    found, match_position));
        end else begin
          want = expected_outcomes.pop_front();
          if (found !== want.found)
            report_mismatch($sformatf("found %0b, expected %0b", found, want.found));
          if (match_position !== want.position)
            report_mismatch($sformatf("match_position %0d, expected %0d",
                                      match_position, want.position));
        end
      end
    end
  end

  // Give up when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (text_valid && text_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int                       len_reg;
    int                       eff;
    int                       hay_len;
    int                       at;
    int                       phase;
    int                       phase_start;
    logic                     plant;
    logic [BYTE_BITS-1:0]     value;
    logic [BYTE_BITS-1:0]     alpha [4];
    logic [BYTE_BITS-1:0]     pattern [NEEDLE_STORE_BYTES];
    logic [CFG_DATA_BITS-1:0] words [4];
    logic [CFG_DATA_BITS-1:0] len_word;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table.
    for (int r = 0; r < SCRIPT_ROWS; r++) begin
      if (SCRIPT[r].kind == ROW_WRITE) begin
        wait_drained();
        write_reg(SCRIPT[r].idx, SCRIPT[r].data);
      end else begin
        push_byte(SCRIPT[r].value, SCRIPT[r].last, SCRIPT[r].typed,
                  SCRIPT[r].want_found, SCRIPT[r].want_pos);
      end
    end

    // Random phases, each with a fresh needle drawn from a small alphabet.
    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      wait_drained();
      case (phase)
        0: len_reg = NEEDLE_STORE_BYTES;
        1: len_reg = (1 << LEN_REG_BITS) - 1;
        2: len_reg = 0;
        3: len_reg = 1;
        default: begin
          len_reg = ($urandom_range(0, 3) == 0) ? $urandom_range(0, (1 << LEN_REG_BITS) - 1)
                                                : $urandom_range(1, 8);
        end
      endcase
      eff = (len_reg > NEEDLE_STORE_BYTES) ? NEEDLE_STORE_BYTES : len_reg;
      for (int k = 0; k < 4; k++) alpha[k] = BYTE_BITS'($urandom);
      // Bytes past the active length are random and must not matter.
      for (int j = 0; j < NEEDLE_STORE_BYTES; j++) begin
        pattern[j] = (j < eff) ? alpha[$urandom_range(0, 3)] : BYTE_BITS'($urandom);
        words[j / BYTES_PER_REG][BYTE_BITS * (j % BYTES_PER_REG) +: BYTE_BITS] = pattern[j];
      end
      len_word = {$urandom, $urandom};
      len_word[LEN_REG_BITS-1:0] = LEN_REG_BITS'(len_reg);
      write_reg(REG_NEEDLE_LENGTH, len_word);
      for (int w = 0; w < 4; w++) write_reg(CFG_INDEX_BITS'(REG_NEEDLE_LO + w), words[w]);
      if ($urandom_range(0, 2) == 0) begin
        write_reg(CFG_INDEX_BITS'($urandom_range(REG_UNUSED_FIRST, REG_INDEX_TOP)),
                  {$urandom, $urandom});
      end

      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS && items_sent < TOTAL_ITEMS) begin
        if (eff > 1 && $urandom_range(0, 7) == 0) hay_len = $urandom_range(1, eff - 1);
        else hay_len = $urandom_range(1, eff + 16);
        plant = (hay_len >= eff) && ($urandom_range(0, 3) != 0);
        at = plant ? $urandom_range(0, hay_len - eff) : 0;
        for (int k = 0; k < hay_len; k++) begin
          if (plant && k >= at && k < at + eff) value = pattern[k - at];
          else if ($urandom_range(0, 5) == 0) value = BYTE_BITS'($urandom);
          else value = alpha[$urandom_range(0, 3)];
          push_byte(value, k == hay_len - 1, 1'b0, 1'b0, '0);
        end
      end
      phase++;
    end

    wait_drained();
    if (mismatch_count == 0 && expected_outcomes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
